### rtl/kslot_pkg.sv
// ----------------------------------------------------------------------------
// kslot_pkg
// Shared types and constants for the key slot unlock checker.
// ----------------------------------------------------------------------------
package kslot_pkg;

  localparam logic [63:0] MIX_BASIS   = 64'd1469598103934665603;
  localparam logic [63:0] MIX_PRIME   = 64'd1099511628211;
  localparam logic [63:0] KDF_MINIMUM = 64'd1000;
  localparam logic [9:0]  BITS_128    = 10'd128;
  localparam logic [9:0]  BITS_256    = 10'd256;
  localparam logic [9:0]  BITS_512    = 10'd512;

  typedef enum logic [2:0] {
    KIND_FORMAT = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_VERIFY = 3'd2,
    KIND_UNLOCK = 3'd3,
    KIND_LOCK   = 3'd4,
    KIND_QUERY  = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_BAD_SLOT = 4'd1,
    ST_UNLOCKED = 4'd2,
    ST_BAD_SIZE = 4'd3,
    ST_LOW_KDF  = 4'd4,
    ST_ZERO_KEY = 4'd5,
    ST_USED     = 4'd6,
    ST_EMPTY    = 4'd7,
    ST_MISMATCH = 4'd8,
    ST_LOCKED   = 4'd9,
    ST_UNKNOWN  = 4'd10
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_RD, S_RDW, S_MIXA, S_MIXB, S_MIXC, S_CHECK,
    S_SUMRD, S_SUMRDW, S_SUMA, S_SUMB, S_SUMC, S_SUMD, S_DONE
  } state_t;

  // Request from the sequencer to the multiplier unit.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
  } mul_req_t;

endpackage

### rtl/kslot_mul.sv
// ----------------------------------------------------------------------------
// kslot_mul
// Registered multiply by the mix prime; the result appears in the cycle after start.
// ----------------------------------------------------------------------------
module kslot_mul
  import kslot_pkg::*;
(
  input  logic        clk,
  input  mul_req_t    req,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod_r <= req.a * MIX_PRIME;
    end
  end

  assign prod = prod_r;

endmodule

### rtl/kslot_mem.sv
// ----------------------------------------------------------------------------
// kslot_mem
// Slot store: used flag, iteration count and key reference per slot.
// ----------------------------------------------------------------------------
module kslot_mem #(
  parameter int SLOT_COUNT = 8,
  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [128:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [128:0]  rdata
);

  logic [128:0] mem [SLOT_COUNT];
  logic [128:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/key_slot_unlock_checker_top.sv
// ----------------------------------------------------------------------------
// key_slot_unlock_checker_top
// Key slot table with two-multiply key mixing and a header checksum.
// ----------------------------------------------------------------------------
// Channel | Direction | Content
// in_     | slave     | command transfer
// out_    | master    | result transfer
// cfg_    | write     | volume magic
// A command that changes nothing runs S_RD, S_RDW, S_MIXA, S_MIXB, S_MIXC and
// S_CHECK, then S_DONE presents its result. A change recomputes the checksum
// slot by slot in S_SUMRD, S_SUMRDW, S_SUMA, S_SUMB, S_SUMC and S_SUMD, and a
// format first clears every slot in S_CLEAR. The state order is set by the
// shared 64-bit multiplier and the slot memory port. After reset a clearing pass
// over every slot runs and the checksum follows; no command is taken meanwhile.
// One command is handled at a time; a held result blocks the next one, and
// the input is ready again in the cycle after the result transfer.
module key_slot_unlock_checker_top
  import kslot_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // kind[2:0], slot[6:3], iter_count[70:7], key_value[134:71],
  // device[198:135], size_bits[208:199], zero fill
  input  logic [215:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[3:0], is_open[4], header_sum[35:5], zero fill
  output logic [39:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  state_t state_r, state_nxt;
  logic [63:0] magic_r;
  logic        open_r, open_nxt;
  logic [63:0] dev_r, dev_nxt;
  logic [9:0]  ksz_r, ksz_nxt;
  logic [63:0] csum_r, csum_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic [63:0] iter_r, iter_nxt, key_r, key_nxt, qdev_r, qdev_nxt;
  logic [9:0]  bits_r, bits_nxt;
  logic [63:0] h_r, h_nxt, m_r, m_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [3:0]  st_r, st_nxt;
  logic [30:0] sum_r, sum_nxt;
  logic        ov_r, ov_nxt;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [128:0] wdata, rdata;
  mul_req_t    req;
  logic [63:0] prod;
  logic        slot_ok;

  kslot_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );
  kslot_mul u_mul (.clk, .req, .prod);

  assign slot_ok = {{(32-4){1'b0}}, slot_r} < SLOT_COUNT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      magic_r <= '0;
      open_r  <= 1'b0;
      dev_r   <= '0;
      ksz_r   <= '0;
      idx_r   <= '0;
      ov_r    <= 1'b0;
      kind_r  <= KIND_QUERY;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) magic_r <= cfg_wdata;
      open_r <= open_nxt;
      dev_r  <= dev_nxt;
      ksz_r  <= ksz_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
      kind_r <= kind_nxt;
    end
    csum_r <= csum_nxt;
    slot_r <= slot_nxt;
    iter_r <= iter_nxt;
    key_r  <= key_nxt;
    qdev_r <= qdev_nxt;
    bits_r <= bits_nxt;
    h_r    <= h_nxt;
    m_r    <= m_nxt;
    st_r   <= st_nxt;
    sum_r  <= sum_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    open_nxt = open_r; dev_nxt = dev_r; ksz_nxt = ksz_r; csum_nxt = csum_r;
    kind_nxt = kind_r; slot_nxt = slot_r; iter_nxt = iter_r; key_nxt = key_r;
    qdev_nxt = qdev_r; bits_nxt = bits_r; h_nxt = h_r; m_nxt = m_r;
    idx_nxt = idx_r; st_nxt = st_r; sum_nxt = sum_r; ov_nxt = ov_r;
    we = 1'b0; waddr = idx_r; wdata = '0;
    raddr = slot_r[AW-1:0];
    req.start = 1'b0; req.a = '0;
    in_tready = 1'b0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = !ov_r;
        if (in_tvalid && !ov_r) begin
          kind_nxt = in_tdata[2:0];
          slot_nxt = in_tdata[6:3];
          iter_nxt = in_tdata[70:7];
          key_nxt  = in_tdata[134:71];
          qdev_nxt = in_tdata[198:135];
          bits_nxt = in_tdata[208:199];
          st_nxt = ST_OK;
          sum_nxt = '0;
          state_nxt = S_RD;
        end
      end
      S_CLEAR: begin
        we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == AW'(SLOT_COUNT - 1)) begin
          idx_nxt = '0;
          h_nxt = magic_r ^ {54'd0, ksz_r} ^ {63'd0, open_r};
          state_nxt = S_SUMRD;
        end
      end
      S_RD: state_nxt = S_RDW;
      S_RDW: begin
        // rdata holds the addressed slot when it is in range.
        if (kind_r == KIND_ADD) begin
          m_nxt = MIX_BASIS ^ iter_r ^ key_r;
          if (!slot_ok) st_nxt = ST_BAD_SLOT;
          else if (open_r) st_nxt = ST_UNLOCKED;
          else if (iter_r < KDF_MINIMUM) st_nxt = ST_LOW_KDF;
          else if (key_r == '0) st_nxt = ST_ZERO_KEY;
          else if (rdata[128]) st_nxt = ST_USED;
        end else begin
          m_nxt = MIX_BASIS ^ rdata[127:64] ^ key_r;
          if (!slot_ok) st_nxt = ST_BAD_SLOT;
          else if (!rdata[128]) st_nxt = ST_EMPTY;
        end
        state_nxt = S_MIXA;
      end
      S_MIXA: begin
        req.start = 1'b1; req.a = m_r;
        state_nxt = S_MIXB;
      end
      S_MIXB: begin
        req.start = 1'b1; req.a = prod ^ {17'd0, key_r[63:17]};
        state_nxt = S_MIXC;
      end
      S_MIXC: begin
        m_nxt = (prod == '0) ? 64'd1 : prod;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        idx_nxt = '0;
        state_nxt = S_DONE;
        h_nxt = magic_r ^ {54'd0, ksz_r} ^ {63'd0, open_r};
        case (kind_r)
          KIND_FORMAT: begin
            st_nxt = ST_OK;
            if (open_r) st_nxt = ST_UNLOCKED;
            else if (bits_r != BITS_128 && bits_r != BITS_256 && bits_r != BITS_512)
              st_nxt = ST_BAD_SIZE;
            else begin
              dev_nxt = qdev_r; ksz_nxt = bits_r;
              state_nxt = S_CLEAR;
            end
          end
          KIND_ADD: begin
            if (st_r == ST_OK) begin
              we = 1'b1; waddr = slot_r[AW-1:0];
              wdata = {1'b1, iter_r, m_r};
              state_nxt = S_SUMRD;
            end
          end
          KIND_VERIFY: begin
            if (st_r == ST_OK && m_r != rdata[63:0]) st_nxt = ST_MISMATCH;
          end
          KIND_UNLOCK: begin
            if (open_r) st_nxt = ST_UNLOCKED;
            else if (st_r != ST_OK || m_r != rdata[63:0]) st_nxt = ST_MISMATCH;
            else begin
              open_nxt = 1'b1;
              h_nxt = magic_r ^ {54'd0, ksz_r} ^ 64'd1;
              state_nxt = S_SUMRD;
            end
          end
          KIND_LOCK: begin
            st_nxt = ST_OK;
            if (!open_r) st_nxt = ST_LOCKED;
            else begin
              open_nxt = 1'b0;
              h_nxt = magic_r ^ {54'd0, ksz_r};
              state_nxt = S_SUMRD;
            end
          end
          KIND_QUERY: begin
            st_nxt = ST_OK;
            if (dev_r == qdev_r) sum_nxt = csum_r[30:0];
          end
          default: st_nxt = ST_UNKNOWN;
        endcase
      end
      S_SUMRD: begin
        raddr = idx_r;
        state_nxt = S_SUMRDW;
      end
      S_SUMRDW: begin
        m_nxt = MIX_BASIS ^ rdata[127:64] ^ rdata[63:0];
        key_nxt = rdata[63:0];
        iter_nxt = {63'd0, rdata[128]};
        state_nxt = S_SUMA;
      end
      S_SUMA: begin
        req.start = 1'b1; req.a = m_r;
        state_nxt = S_SUMB;
      end
      S_SUMB: begin
        req.start = 1'b1; req.a = prod ^ {17'd0, key_r[63:17]};
        state_nxt = S_SUMC;
      end
      S_SUMC: begin
        req.start = 1'b1;
        req.a = iter_r[0] ? (h_r ^ ((prod == '0) ? 64'd1 : prod)) : h_r;
        state_nxt = S_SUMD;
      end
      S_SUMD: begin
        h_nxt = prod;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == AW'(SLOT_COUNT - 1)) begin
          csum_nxt = (prod == '0) ? 64'd1 : prod;
          state_nxt = (kind_r == KIND_QUERY) ? S_IDLE : S_DONE;
        end else begin
          state_nxt = S_SUMRD;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, sum_r, open_r, st_r};

endmodule

### rtl/kslot_checker.sv
// ----------------------------------------------------------------------------
// kslot_checker
// Port-level checks for the key slot unlock checker.
// ----------------------------------------------------------------------------
module kslot_checker
  import kslot_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [39:0]  out_tdata
);

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("Result changed while stalled.");

  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("Command taken while a result waits.");

  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("Result appeared one cycle after a command.");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= ST_UNKNOWN)
    else $error("Status code out of range.");

endmodule

bind key_slot_unlock_checker_top kslot_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

### sim/key_slot_unlock_checker_top_tb.sv
// ----------------------------------------------------------------------------
// key_slot_unlock_checker_top_tb
// Streams key slot commands into the checker and compares every result
// against a behavioral model of the slot table, volume state and header
// checksum, partly under random idling on both channels.
// ----------------------------------------------------------------------------
module key_slot_unlock_checker_top_tb
  import kslot_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] KIND_BAD6 = 3'd6;
  localparam logic [2:0] KIND_BAD7 = 3'd7;

  typedef struct packed {
    logic [3:0]  status;
    logic        is_open;
    logic [30:0] header_sum;
  } result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [215:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [39:0]  out_tdata;
  logic         cfg_we = 1'b0;
  logic [63:0]  cfg_wdata = '0;

  key_slot_unlock_checker_top #(.SLOT_COUNT(SLOTS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model state of the volume header.
  logic [63:0] m_magic;
  logic        m_used [SLOTS];
  logic [63:0] m_iter [SLOTS];
  logic [63:0] m_ref [SLOTS];
  logic        m_open;
  logic [63:0] m_device;
  logic [9:0]  m_key_size;
  logic [63:0] m_checksum;

  result_t expected_results[$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_cycles = 0;
  int      quiet_cycles = 0;

  function automatic logic [63:0] key_mix(logic [63:0] a, logic [63:0] b);
    logic [63:0] h;
    h = (MIX_BASIS ^ a ^ b) * MIX_PRIME;
    h = (h ^ (b >> 17)) * MIX_PRIME;
    return (h == 0) ? 64'd1 : h;
  endfunction

  function automatic void refresh_checksum();
    logic [63:0] h;
    h = m_magic ^ {54'd0, m_key_size} ^ {63'd0, m_open};
    for (int i = 0; i < SLOTS; i++) begin
      if (m_used[i]) h ^= key_mix(m_iter[i], m_ref[i]);
      h = h * MIX_PRIME;
    end
    m_checksum = (h == 0) ? 64'd1 : h;
  endfunction

  function automatic void clear_volume_slots();
    for (int i = 0; i < SLOTS; i++) begin
      m_used[i] = 1'b0;
      m_iter[i] = '0;
      m_ref[i] = '0;
    end
  endfunction

  function automatic logic [3:0] key_check(logic [3:0] s, logic [63:0] key);
    if (s >= SLOTS) return ST_BAD_SLOT;
    if (!m_used[s]) return ST_EMPTY;
    return (key_mix(m_iter[s], key) == m_ref[s]) ? ST_OK : ST_MISMATCH;
  endfunction

  function automatic result_t apply_command(logic [2:0] kind, logic [3:0] s,
      logic [63:0] iter, logic [63:0] key, logic [63:0] dev, logic [9:0] bits);
    result_t r;
    r = '0;
    case (kind)
      KIND_FORMAT: begin
        if (m_open) r.status = ST_UNLOCKED;
        else if (bits != BITS_128 && bits != BITS_256 && bits != BITS_512)
          r.status = ST_BAD_SIZE;
        else begin
          clear_volume_slots();
          m_device = dev;
          m_key_size = bits;
          m_open = 1'b0;
          refresh_checksum();
        end
      end
      KIND_ADD: begin
        if (s >= SLOTS) r.status = ST_BAD_SLOT;
        else if (m_open) r.status = ST_UNLOCKED;
        else if (iter < KDF_MINIMUM) r.status = ST_LOW_KDF;
        else if (key == 0) r.status = ST_ZERO_KEY;
        else if (m_used[s]) r.status = ST_USED;
        else begin
          m_used[s] = 1'b1;
          m_iter[s] = iter;
          m_ref[s] = key_mix(iter, key);
          refresh_checksum();
        end
      end
      KIND_VERIFY: r.status = key_check(s, key);
      KIND_UNLOCK: begin
        if (m_open) r.status = ST_UNLOCKED;
        else if (key_check(s, key) != ST_OK) r.status = ST_MISMATCH;
        else begin
          m_open = 1'b1;
          refresh_checksum();
        end
      end
      KIND_LOCK: begin
        if (!m_open) r.status = ST_LOCKED;
        else begin
          m_open = 1'b0;
          refresh_checksum();
        end
      end
      KIND_QUERY: if (m_device == dev) r.header_sum = m_checksum[30:0];
      default: r.status = ST_UNKNOWN;
    endcase
    r.is_open = m_open;
    return r;
  endfunction

  // Key material remembered per slot so that unlocks can succeed.
  logic [63:0] slot_keys [SLOTS];

  task automatic send_command(logic [2:0] kind, logic [3:0] s, logic [63:0] iter,
      logic [63:0] key, logic [63:0] dev, logic [9:0] bits);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, bits, dev, key, iter, s, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(apply_command(kind, s, iter, key, dev, bits));
    if (kind == KIND_ADD && s < SLOTS && expected_results[$].status == ST_OK)
      slot_keys[s] = key;
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_magic(logic [63:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_magic = value;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_command(KIND_QUERY, 0, 0, 0, 0, 0);
    send_command(KIND_FORMAT, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1023);
    send_command(KIND_FORMAT, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, BITS_512);
    send_command(KIND_FORMAT, 0, 0, 0, 64'h1234, BITS_128);
    send_command(KIND_FORMAT, 0, 0, 0, 64'h1234, BITS_256);
    send_command(KIND_ADD, 4'd15, 64'd5000, 64'd7, 0, 0);
    send_command(KIND_ADD, 4'd8, 64'd5000, 64'd7, 0, 0);
    send_command(KIND_ADD, 0, 64'd999, 64'd7, 0, 0);
    send_command(KIND_ADD, 0, KDF_MINIMUM, 64'd0, 0, 0);
    send_command(KIND_ADD, 0, KDF_MINIMUM, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    send_command(KIND_ADD, 0, 64'd2000, 64'd3, 0, 0);
    send_command(KIND_ADD, 4'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 0, 0);
    send_command(KIND_VERIFY, 4'd9, 0, 64'd1, 0, 0);
    send_command(KIND_VERIFY, 4'd3, 0, 64'd1, 0, 0);
    send_command(KIND_VERIFY, 0, 0, 64'd1, 0, 0);
    send_command(KIND_VERIFY, 4'd7, 0, 64'd1, 0, 0);
    send_command(KIND_LOCK, 0, 0, 0, 0, 0);
    send_command(KIND_UNLOCK, 4'd3, 0, 64'd1, 0, 0);
    send_command(KIND_UNLOCK, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    send_command(KIND_UNLOCK, 0, 0, 64'd1, 0, 0);
    send_command(KIND_FORMAT, 0, 0, 0, 0, BITS_128);
    send_command(KIND_ADD, 4'd1, 64'd5000, 64'd9, 0, 0);
    send_command(KIND_QUERY, 0, 0, 0, 64'h1234, 0);
    send_command(KIND_LOCK, 0, 0, 0, 0, 0);
    send_command(KIND_BAD6, 0, 0, 0, 0, 0);
    send_command(KIND_BAD7, 4'd15, 0, 0, 0, 0);
  endtask

  task automatic random_command();
    logic [2:0]  kind;
    logic [3:0]  s;
    logic [63:0] key;
    logic [63:0] iter;
    logic [63:0] dev;
    logic [9:0]  bits;
    int          pick;
    pick = $urandom_range(99);
    s = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(SLOTS - 1));
    iter = ($urandom_range(7) == 0) ? 64'($urandom_range(1100)) : rand64();
    key = ($urandom_range(15) == 0) ? 64'd0 : rand64();
    dev = ($urandom_range(2) == 0) ? rand64() : m_device;
    bits = ($urandom_range(4) == 0) ? 10'($urandom) :
           (($urandom_range(2) == 0) ? BITS_128 :
            (($urandom_range(1) == 0) ? BITS_256 : BITS_512));
    if (pick < 5) kind = KIND_FORMAT;
    else if (pick < 35) kind = KIND_ADD;
    else if (pick < 50) kind = KIND_VERIFY;
    else if (pick < 65) kind = KIND_UNLOCK;
    else if (pick < 78) kind = KIND_LOCK;
    else if (pick < 97) kind = KIND_QUERY;
    else kind = 3'($urandom_range(7));
    if ((kind == KIND_VERIFY || kind == KIND_UNLOCK) && s < SLOTS &&
        m_used[s] && $urandom_range(3) != 0)
      key = slot_keys[s];
    send_command(kind, s, iter, key, dev, bits);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) random_command();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    test_random(30);
    while (hold_cycles != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[3:0], out_tdata[4], out_tdata[35:5]};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.is_open !== want.is_open ||
            got.header_sum !== want.header_sum) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected status %0d open %0b sum %h, got %0d %0b %h",
                     want.status, want.is_open, want.header_sum,
                     got.status, got.is_open, got.header_sum);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    m_magic = '0;
    clear_volume_slots();
    m_open = 1'b0;
    m_device = '0;
    m_key_size = '0;
    refresh_checksum();
    for (int i = 0; i < SLOTS; i++) slot_keys[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    write_magic(64'hFFFF_FFFF_FFFF_FFFF);
    send_idle_pct = 11;
    recv_idle_pct = 83;
    test_random(300);
    write_magic(rand64());
    send_idle_pct = 83;
    recv_idle_pct = 11;
    test_random(300);
    write_magic(64'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(370);
    drain_results();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
